/* src/tpim_pkg.sv */
// shared constants and types for the tensor permute index map
`default_nettype none
package tpim_pkg;
    localparam int DIMS           = 4;
    localparam int MAX_RANK_DEF   = 4;
    localparam int INDEX_BITS_DEF = 32;
    localparam int SIZE_W         = 16;
    localparam int RANK_W         = 3;
    localparam int AXIS_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int IN_W           = 32;
    localparam int OUT_W          = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK  = 3'd0,
        REG_SIZE0 = 3'd1,
        REG_SIZE1 = 3'd2,
        REG_SIZE2 = 3'd3,
        REG_SIZE3 = 3'd4,
        REG_AXIS  = 3'd5
    } t_reg_idx;

    function automatic int lanes_of(input int max_rank);
        lanes_of = (max_rank < DIMS) ? max_rank : DIMS;
    endfunction
endpackage
`default_nettype wire

/* src/tensor_permute_index_map.sv */
// top level of the tensor permute index map
// Maps a row-major input element index to its index in the axis-permuted
// tensor. One item is taken per cycle while o_stall is low; each result
// passes through the chain of division cells (one quotient bit per cell,
// INDEX_BITS cells for each of min(4, MAX_RANK) dimensions) and then the
// output register. After each register write the input stalls while the
// strides are rederived.
`default_nettype none
module tensor_permute_index_map import tpim_pkg::*; #(
    parameter int MAX_RANK   = MAX_RANK_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [IN_W-1:0]       i_linear_index,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [OUT_W-1:0]           o_permuted_index
);
    localparam int LANES = lanes_of(MAX_RANK);
    localparam int W     = INDEX_BITS;
    localparam int N     = LANES * W;

    logic             w_busy;
    logic [LANES-1:0] w_lane_on;
    logic [W-1:0]     w_istr [LANES];
    logic [W-1:0]     w_wsel [LANES];
    logic             w_valid [N+1];
    logic [W-1:0]     w_rem [N+1];
    logic [W-1:0]     w_acc [N+1];
    logic             w_advance;
    logic [63:0]      w_in_ext;
    logic [63:0]      w_sum_ext;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out;

    tpim_cfg #(
        .MAX_RANK   (MAX_RANK),
        .INDEX_BITS (INDEX_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_busy     (w_busy),
        .o_lane_on  (w_lane_on),
        .o_istr     (w_istr),
        .o_wsel     (w_wsel)
    );

    assign w_advance = !(w_valid[N] && r_out_valid && i_stall);
    assign o_stall   = w_busy || !w_advance;
    assign w_in_ext  = 64'(i_linear_index);
    assign w_valid[0] = i_valid && !o_stall;
    assign w_rem[0]   = w_in_ext[W-1:0];
    assign w_acc[0]   = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        tpim_cell #(
            .W     (W),
            .SHIFT (W - 1 - (k % W))
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_active  (w_lane_on[k / W]),
            .i_divisor (w_istr[k / W]),
            .i_weight  (w_wsel[k / W]),
            .i_valid   (w_valid[k]),
            .i_rem     (w_rem[k]),
            .i_acc     (w_acc[k]),
            .o_valid   (w_valid[k+1]),
            .o_rem     (w_rem[k+1]),
            .o_acc     (w_acc[k+1])
        );
    end

    // any remainder left after the last cell is added to the accumulated index
    assign w_sum_ext = 64'(W'(w_acc[N] + w_rem[N]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= w_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_out_valid || !i_stall) && w_valid[N]) begin
            r_out <= w_sum_ext[OUT_W-1:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_permuted_index = r_out;

    a_cfg_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_addr <= REG_AXIS)) |=> o_stall)
        else $error("input not stalled after register write");

    a_chain_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[N] && r_out_valid && i_stall) |=> ($stable(w_rem[N]) && w_valid[N]))
        else $error("chain moved while output held");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

/* src/tpim_cell.sv */
// one restoring division step that also accumulates the scaled quotient bit
`default_nettype none
module tpim_cell import tpim_pkg::*; #(
    parameter int W     = INDEX_BITS_DEF,
    parameter int SHIFT = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_advance,
    input  wire logic         i_active,
    input  wire logic [W-1:0] i_divisor,
    input  wire logic [W-1:0] i_weight,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_acc,
    output logic              o_valid,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_acc
);
    logic         r_valid;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_acc;
    logic         w_take;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_acc;

    always_comb begin
        w_take = i_active && ((i_rem >> SHIFT) >= i_divisor);
        n_rem  = w_take ? (i_rem - (i_divisor << SHIFT)) : i_rem;
        n_acc  = w_take ? (i_acc + (i_weight << SHIFT)) : i_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
endmodule
`default_nettype wire

/* src/tpim_cfg.sv */
// configuration registers and stride derivation sequencer
`default_nettype none
module tpim_cfg import tpim_pkg::*; #(
    parameter int MAX_RANK   = MAX_RANK_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int LANES     = lanes_of(MAX_RANK),
    localparam int IW        = (LANES > 1) ? $clog2(LANES) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_busy,
    output logic [LANES-1:0]           o_lane_on,
    output logic [INDEX_BITS-1:0]      o_istr [LANES],
    output logic [INDEX_BITS-1:0]      o_wsel [LANES]
);
    localparam int W = INDEX_BITS;

    typedef enum logic [1:0] {S_IDLE, S_DRV, S_SEL} t_state;

    t_state              r_state;
    logic [RANK_W-1:0]   r_rank;
    logic [SIZE_W-1:0]   r_size [DIMS];
    logic [AXIS_W-1:0]   r_axis;
    logic [IW-1:0]       r_cnt;
    logic [W-1:0]        r_iacc;
    logic [W-1:0]        r_oacc;
    logic [W-1:0]        r_istr [LANES];
    logic [W-1:0]        r_ostr [LANES];
    logic [W-1:0]        r_wsel [LANES];
    logic [LANES-1:0]    r_lane_on;
    logic [3:0]          w_used;
    logic [IW-1:0]       w_inv [LANES];
    logic [SIZE_W-1:0]   w_iext;
    logic [SIZE_W-1:0]   w_oext;

    function automatic logic [SIZE_W-1:0] extent(input logic [SIZE_W-1:0] s);
        extent = (s == '0) ? SIZE_W'(1) : s;
    endfunction

    function automatic logic [1:0] axis_at(input logic [AXIS_W-1:0] ax, input int pos);
        axis_at = ax[2*pos +: 2];
    endfunction

    always_comb begin
        w_used = {1'b0, r_rank};
        if (w_used < 4'd1) w_used = 4'd1;
        if (w_used > 4'(LANES)) w_used = 4'(LANES);
        for (int a = 0; a < LANES; a++) begin
            w_inv[a] = '0;
            for (int i = 0; i < LANES; i++) begin
                if ((4'(i) < w_used) && (4'(a) < w_used) &&
                    (axis_at(r_axis, i) == 2'(a))) begin
                    w_inv[a] = IW'(i);
                end
            end
        end
        w_iext = extent(r_size[2'(r_cnt)]);
        w_oext = extent(r_size[axis_at(r_axis, int'(r_cnt))]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rank    <= RANK_W'(1);
            r_axis    <= AXIS_W'(228);
            r_cnt     <= '0;
            r_iacc    <= W'(1);
            r_oacc    <= W'(1);
            r_lane_on <= LANES'(1);
            for (int d = 0; d < DIMS; d++) r_size[d] <= SIZE_W'(1);
            for (int d = 0; d < LANES; d++) begin
                r_istr[d] <= W'(1);
                r_ostr[d] <= W'(1);
                r_wsel[d] <= W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr) inside
                REG_RANK: begin
                    r_rank <= i_cfg_data[RANK_W-1:0];
                end
                REG_SIZE0, REG_SIZE1, REG_SIZE2, REG_SIZE3: begin
                    r_size[2'(i_cfg_addr - REG_SIZE0)] <= i_cfg_data[SIZE_W-1:0];
                end
                REG_AXIS: begin
                    r_axis <= i_cfg_data[AXIS_W-1:0];
                end
                default: begin
                end
            endcase
            if (i_cfg_addr <= REG_AXIS) begin
                r_state <= S_DRV;
                r_cnt   <= IW'(LANES - 1);
                r_iacc  <= W'(1);
                r_oacc  <= W'(1);
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_DRV: begin
                    if ({{(4-IW){1'b0}}, r_cnt} < w_used) begin
                        r_istr[r_cnt] <= r_iacc;
                        r_ostr[r_cnt] <= r_oacc;
                        r_iacc        <= W'(r_iacc * w_iext);
                        r_oacc        <= W'(r_oacc * w_oext);
                    end else begin
                        r_istr[r_cnt] <= W'(1);
                        r_ostr[r_cnt] <= W'(1);
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_SEL;
                    end else begin
                        r_cnt <= r_cnt - IW'(1);
                    end
                end
                S_SEL: begin
                    for (int d = 0; d < LANES; d++) begin
                        r_wsel[d]    <= r_ostr[w_inv[d]];
                        r_lane_on[d] <= (4'(d) < w_used) && (r_istr[d] != '0);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_lane_on = r_lane_on;
    assign o_istr    = r_istr;
    assign o_wsel    = r_wsel;
endmodule
`default_nettype wire
